### hdl/srhp_pkg.sv
package srhp_pkg;

	localparam logic [15:0] MAX_PACKET_BYTES = 16'd4096;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_SPEC,
		PH_AREA,
		PH_IDENT,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVERSIZE = 3'd1,
		ST_CATEGORY = 3'd2,
		ST_TOO_LONG = 3'd3,
		ST_PAST_END = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic        first_byte;
		logic [15:0] buffer_size;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  source_area;
		logic [7:0]  source_ident;
		logic        length_short;
		logic [15:0] record_length;
	} out_item_t;

endpackage

### hdl/srhp_if.sv
interface srhp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_value;
	logic        first_byte;
	logic [15:0] buffer_size;

	modport source (output valid, output byte_value, output first_byte,
		output buffer_size, input ready);
	modport sink (input valid, input byte_value, input first_byte,
		input buffer_size, output ready);
endinterface

interface srhp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  source_area;
	logic [7:0]  source_ident;
	logic        length_short;
	logic [15:0] record_length;

	modport source (output valid, output status, output source_area,
		output source_ident, output length_short, output record_length,
		input ready);
	modport sink (input valid, input status, input source_area,
		input source_ident, input length_short, input record_length,
		output ready);
endinterface

interface srhp_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/surveillance_record_header_parser_core.sv
// Channel | Dir | Payload
// rx      | in  | byte_value[7:0], first_byte, buffer_size[15:0]
// tx      | out | status[2:0], source_area[7:0], source_ident[7:0],
//         |     | length_short, record_length[15:0]
// cfg     | in  | data[7:0] -> expected category
//
// One byte per cycle unless tx stalls; the deciding byte is registered, parsed, and its result registered for tx.
// The rate is set by the parse stage, which updates the header state once per byte.
// arst_n clears the parse state, the category register and both valid flags.
// A stalled result holds the parse stage; rx ready drops once that stage is full too.
module surveillance_record_header_parser_core (
	input logic clk,
	input logic arst_n,
	srhp_in_if.sink    rx,
	srhp_out_if.source tx,
	srhp_cfg_if.sink   cfg
);
	import srhp_pkg::*;

	logic        valid_s1;
	in_item_t    item_s1;
	logic [7:0]  category_q;
	phase_t      phase_q, phase_d;
	logic [15:0] position_q;
	logic [15:0] length_q;
	logic [15:0] bufsize_q;
	logic [7:0]  area_q;
	logic        short_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        out_free;
	logic        take_s1;
	logic        emit;
	out_item_t   res;
	logic [15:0] length_lo;
	logic [16:0] next_pos;
	logic        cat_ok;
	logic        size_ok;

	assign out_free  = !out_valid_q || tx.ready;
	assign take_s1   = valid_s1 && out_free;
	assign rx.ready  = !valid_s1 || out_free;
	assign cfg.ready = 1'b1;

	assign length_lo = {length_q[15:8], item_s1.byte_value};
	assign next_pos  = {1'b0, position_q} + 17'd1;
	assign size_ok   = item_s1.buffer_size <= MAX_PACKET_BYTES;
	assign cat_ok    = item_s1.byte_value == category_q;

	always_comb begin
		phase_d = phase_q;
		if (item_s1.first_byte) begin
			phase_d = (size_ok && cat_ok) ? PH_LEN_HI : PH_DONE;
		end else begin
			unique case (phase_q)
				PH_LEN_HI: phase_d = PH_LEN_LO;
				PH_LEN_LO: phase_d = (length_lo > bufsize_q) ? PH_DONE : PH_SPEC;
				PH_SPEC: begin
					if (item_s1.byte_value[0])
						phase_d = (next_pos >= {1'b0, length_q}) ? PH_DONE : PH_SPEC;
					else
						phase_d = PH_AREA;
				end
				PH_AREA:  phase_d = PH_IDENT;
				PH_IDENT: phase_d = PH_DONE;
				default:  phase_d = phase_q;
			endcase
		end
	end

	always_comb begin
		emit = 1'b0;
		res  = '0;
		if (item_s1.first_byte) begin
			if (!size_ok) begin
				emit       = 1'b1;
				res.status = ST_OVERSIZE;
			end else if (!cat_ok) begin
				emit       = 1'b1;
				res.status = ST_CATEGORY;
			end
		end else begin
			unique case (phase_q)
				PH_LEN_LO: begin
					if (length_lo > bufsize_q) begin
						emit              = 1'b1;
						res.status        = ST_TOO_LONG;
						res.record_length = length_lo;
					end
				end
				PH_SPEC: begin
					if (item_s1.byte_value[0] && next_pos >= {1'b0, length_q}) begin
						emit              = 1'b1;
						res.status        = ST_PAST_END;
						res.length_short  = short_q;
						res.record_length = length_q;
					end
				end
				PH_IDENT: begin
					emit              = 1'b1;
					res.status        = ST_OK;
					res.source_area   = area_q;
					res.source_ident  = item_s1.byte_value;
					res.length_short  = short_q;
					res.record_length = length_q;
				end
				default: emit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1.byte_value  <= rx.byte_value;
			item_s1.first_byte  <= rx.first_byte;
			item_s1.buffer_size <= rx.buffer_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			category_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			category_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			position_q <= '0;
			length_q   <= '0;
			bufsize_q  <= '0;
			area_q     <= '0;
			short_q    <= 1'b0;
		end else if (take_s1) begin
			phase_q <= phase_d;
			if (item_s1.first_byte) begin
				bufsize_q  <= item_s1.buffer_size;
				position_q <= '0;
				length_q   <= '0;
				area_q     <= '0;
				short_q    <= 1'b0;
			end else begin
				unique case (phase_q)
					PH_LEN_HI: length_q <= {item_s1.byte_value, 8'h00};
					PH_LEN_LO: begin
						length_q <= length_lo;
						if (length_lo <= bufsize_q) begin
							short_q    <= length_lo < bufsize_q;
							position_q <= 16'd3;
						end
					end
					PH_SPEC: begin
						if (item_s1.byte_value[0] && next_pos < {1'b0, length_q})
							position_q <= next_pos[15:0];
					end
					PH_AREA: area_q <= item_s1.byte_value;
					default: area_q <= area_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && emit) begin
			out_q <= res;
		end
	end

	assign tx.valid         = out_valid_q;
	assign tx.status        = out_q.status;
	assign tx.source_area   = out_q.source_area;
	assign tx.source_ident  = out_q.source_ident;
	assign tx.length_short  = out_q.length_short;
	assign tx.record_length = out_q.record_length;

`ifndef SYNTHESIS
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && emit) |=> (phase_q == PH_DONE && out_valid_q))
		else $error("result issued without closing the packet");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take_s1 && !item_s1.first_byte && (phase_q == PH_IDLE || phase_q == PH_DONE))
		|-> !emit)
		else $error("stray byte produced a result");

	a_reject_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status == ST_OVERSIZE || out_q.status == ST_CATEGORY))
		|-> (out_q.record_length == '0 && !out_q.length_short))
		else $error("header reject carries length data");

	a_accept_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> rx.ready)
		else $error("input stalled with empty result register");
`endif

endmodule
